/* src/wfba_pkg.sv */
// Shared types, codes and helpers for the worst-fit block allocator.
package wfba_pkg;

  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int SUM_W     = 20;
  localparam int ADD_W     = 32;
  localparam int PORT_SZ_W = 16;
  localparam int PORT_IX_W = 4;
  localparam int STATUS_W  = 3;
  localparam int CFG_W     = 5;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // request opcodes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ALLOC  = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REPORT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic clear;
    logic load_en;
    logic grant_en;
  } wfba_ctl_t;

  // saturating add of a block-sized value onto a running sum
  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [ADD_W-1:0] b);
    logic [ADD_W:0] s;
    s = (ADD_W+1)'(a) + (ADD_W+1)'(b);
    return (s > (ADD_W+1)'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

/* src/worst_fit_block_allocator.sv */
// Top level of the worst-fit block allocator: sequencer, totals and cell chain.
//
// Usage
//   Input channel (in_valid/in_ready, in_op, in_size) takes one request at a
//   time: load a block size, allocate, report totals, or clear the table.
//   Result channel (out_valid/out_ready) returns one result per request:
//   status, block index, leftover, internal total and external total.
//   Config channel (cfg_valid/cfg_ready, cfg_blocks_in_use) sets how many
//   table entries are loadable and scanned; write it only while idle.
// Timing
//   Load and clear: accept, then S_RESP loads the output register.
//   Allocate and report: S_START, S_SCAN, S_RESP. The scan is a wavefront
//   that moves one cell per cycle down the chain of MAX_BLOCKS cells, each
//   cell comparing its own entry against the best candidate handed to it.
//   One request is in flight at a time; in_ready returns once the result
//   sits in the output register, so a new request overlaps its delivery.
// Reset
//   Synchronous, active low. Clears busy flags, load count, totals, the
//   refused flag and the chain valids; blocks_in_use returns to 16. Stored
//   block sizes are not cleared and are only read once loaded.
// Backpressure
//   A stalled out_ready holds the result; a finished next result waits in
//   the sequencer until the output register frees up.
module worst_fit_block_allocator #(
  parameter int MAX_BLOCKS = wfba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = wfba_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_op,
  input  logic [wfba_pkg::PORT_SZ_W-1:0]  in_size,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [wfba_pkg::STATUS_W-1:0]   out_status,
  output logic [wfba_pkg::PORT_IX_W-1:0]  out_block_index,
  output logic [wfba_pkg::PORT_SZ_W-1:0]  out_leftover,
  output logic [wfba_pkg::SUM_W-1:0]      out_total_internal,
  output logic [wfba_pkg::SUM_W-1:0]      out_total_external,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wfba_pkg::CFG_W-1:0]      cfg_blocks_in_use
);
  import wfba_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  localparam logic [CFG_W-1:0] BIU_RESET = CFG_W'(16);

  // sequencer and totals
  logic [1:0]           state_r, state_nxt;
  logic [CFG_W-1:0]     biu_r;
  logic [CNT_W-1:0]     load_cnt_r, load_cnt_nxt;
  logic [SUM_W-1:0]     int_r, int_nxt;
  logic [SUM_W-1:0]     uns_r, uns_nxt;
  logic                 ref_r, ref_nxt;
  logic [1:0]           op_r, op_nxt;
  logic [SIZE_BITS-1:0] sz_r, sz_nxt;

  // pending result
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [PORT_IX_W-1:0] res_idx_r, res_idx_nxt;
  logic [PORT_SZ_W-1:0] res_left_r, res_left_nxt;
  logic [SUM_W-1:0]     res_int_r, res_int_nxt;
  logic [SUM_W-1:0]     res_ext_r, res_ext_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic [STATUS_W-1:0]  out_status_r;
  logic [PORT_IX_W-1:0] out_idx_r;
  logic [PORT_SZ_W-1:0] out_left_r;
  logic [SUM_W-1:0]     out_int_r;
  logic [SUM_W-1:0]     out_ext_r;

  logic                 in_acc;
  logic [SIZE_BITS-1:0] in_sz;
  logic [CMP_W-1:0]     biu_w;
  logic [CNT_W-1:0]     eff;
  logic [CNT_W-1:0]     lim;
  logic [SIZE_BITS-1:0] left;
  wfba_ctl_t            ctl;
  logic                 inject;

  // scan chain taps, index 0 is the injection point
  logic                 c_valid [0:MAX_BLOCKS];
  logic                 c_found [0:MAX_BLOCKS];
  logic [IDX_W-1:0]     c_idx   [0:MAX_BLOCKS];
  logic [SIZE_BITS-1:0] c_size  [0:MAX_BLOCKS];
  logic [SUM_W-1:0]     c_sum   [0:MAX_BLOCKS];

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign in_sz     = SIZE_BITS'(in_size);

  // effective table size: 0 acts as 1, anything past the table as the table
  assign biu_w = CMP_W'(biu_r);
  always_comb begin
    if (biu_w == '0) begin
      eff = CNT_W'(1);
    end else if (biu_w > CMP_W'(MAX_BLOCKS)) begin
      eff = CNT_W'(MAX_BLOCKS);
    end else begin
      eff = CNT_W'(biu_w);
    end
  end
  assign lim  = (load_cnt_r < eff) ? load_cnt_r : eff;
  assign left = c_size[MAX_BLOCKS] - sz_r;

  assign c_valid[0] = inject;
  assign c_found[0] = 1'b0;
  assign c_idx[0]   = '0;
  assign c_size[0]  = '0;
  assign c_sum[0]   = '0;

  always_comb begin
    state_nxt      = state_r;
    load_cnt_nxt   = load_cnt_r;
    int_nxt        = int_r;
    uns_nxt        = uns_r;
    ref_nxt        = ref_r;
    op_nxt         = op_r;
    sz_nxt         = sz_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_left_nxt   = res_left_r;
    res_int_nxt    = res_int_r;
    res_ext_nxt    = res_ext_r;
    ctl            = '0;
    inject         = 1'b0;
    out_load       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt       = in_op;
          sz_nxt       = in_sz;
          res_idx_nxt  = '0;
          res_left_nxt = '0;
          res_ext_nxt  = '0;
          res_int_nxt  = int_r;
          case (in_op)
            OP_LOAD: begin
              if (load_cnt_r < eff) begin
                ctl.load_en    = 1'b1;
                load_cnt_nxt   = load_cnt_r + CNT_W'(1);
                res_status_nxt = ST_LOADED;
                res_idx_nxt    = PORT_IX_W'(load_cnt_r);
              end else begin
                res_status_nxt = ST_FULL;
              end
              state_nxt = S_RESP;
            end
            OP_CLEAR: begin
              ctl.clear      = 1'b1;
              load_cnt_nxt   = '0;
              int_nxt        = '0;
              uns_nxt        = '0;
              ref_nxt        = 1'b0;
              res_int_nxt    = '0;
              res_status_nxt = ST_CLEARED;
              state_nxt      = S_RESP;
            end
            default: begin
              state_nxt = S_START;
            end
          endcase
        end
      end
      S_START: begin
        inject    = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (c_valid[MAX_BLOCKS]) begin
          if (op_r == OP_ALLOC) begin
            if (c_found[MAX_BLOCKS]) begin
              ctl.grant_en   = 1'b1;
              int_nxt        = sat_add(int_r, ADD_W'(left));
              res_status_nxt = ST_GRANTED;
              res_idx_nxt    = PORT_IX_W'(c_idx[MAX_BLOCKS]);
              res_left_nxt   = PORT_SZ_W'(left);
            end else begin
              ref_nxt        = 1'b1;
              uns_nxt        = sat_add(uns_r, ADD_W'(sz_r));
              res_status_nxt = ST_REFUSED;
            end
          end else begin
            res_status_nxt = ST_REPORT;
            // external fragmentation only counts once something was refused
            // and the free space could have covered it
            if (ref_r && (uns_r <= c_sum[MAX_BLOCKS])) begin
              res_ext_nxt = c_sum[MAX_BLOCKS];
            end
          end
          res_int_nxt = int_nxt;
          state_nxt   = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      biu_r       <= BIU_RESET;
      load_cnt_r  <= '0;
      int_r       <= '0;
      uns_r       <= '0;
      ref_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      int_r       <= int_nxt;
      uns_r       <= uns_nxt;
      ref_r       <= ref_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        biu_r <= cfg_blocks_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    sz_r         <= sz_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_left_r   <= res_left_nxt;
    res_int_r    <= res_int_nxt;
    res_ext_r    <= res_ext_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_idx_r    <= res_idx_r;
      out_left_r   <= res_left_r;
      out_int_r    <= res_int_r;
      out_ext_r    <= res_ext_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_block_index    = out_idx_r;
  assign out_leftover       = out_left_r;
  assign out_total_internal = out_int_r;
  assign out_total_external = out_ext_r;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    wfba_cell #(
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W),
      .CELL_IDX  (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .load_idx  (load_cnt_r[IDX_W-1:0]),
      .load_data (in_sz),
      .grant_idx (c_idx[MAX_BLOCKS]),
      .req_size  (sz_r),
      .lim       (lim),
      .c_valid_i (c_valid[g]),
      .c_found_i (c_found[g]),
      .c_idx_i   (c_idx[g]),
      .c_size_i  (c_size[g]),
      .c_sum_i   (c_sum[g]),
      .c_valid_o (c_valid[g+1]),
      .c_found_o (c_found[g+1]),
      .c_idx_o   (c_idx[g+1]),
      .c_size_o  (c_size[g+1]),
      .c_sum_o   (c_sum[g+1])
    );
  end

endmodule

/* src/wfba_cell.sv */
// One table entry: stored size and busy flag, plus one stage of the scan chain.
module wfba_cell #(
  parameter int SIZE_BITS = 16,
  parameter int IDX_W     = 4,
  parameter int CNT_W     = 5,
  parameter int CELL_IDX  = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  wfba_pkg::wfba_ctl_t      ctl,
  input  logic [IDX_W-1:0]         load_idx,
  input  logic [SIZE_BITS-1:0]     load_data,
  input  logic [IDX_W-1:0]         grant_idx,
  input  logic [SIZE_BITS-1:0]     req_size,
  input  logic [CNT_W-1:0]         lim,
  input  logic                     c_valid_i,
  input  logic                     c_found_i,
  input  logic [IDX_W-1:0]         c_idx_i,
  input  logic [SIZE_BITS-1:0]     c_size_i,
  input  logic [wfba_pkg::SUM_W-1:0] c_sum_i,
  output logic                     c_valid_o,
  output logic                     c_found_o,
  output logic [IDX_W-1:0]         c_idx_o,
  output logic [SIZE_BITS-1:0]     c_size_o,
  output logic [wfba_pkg::SUM_W-1:0] c_sum_o
);
  import wfba_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [SIZE_BITS-1:0] size_r;
  logic                 busy_r;
  logic                 in_range;
  logic                 take;
  logic                 c_valid_r;
  logic                 c_found_r;
  logic [IDX_W-1:0]     c_idx_r;
  logic [SIZE_BITS-1:0] c_size_r;
  logic [SUM_W-1:0]     c_sum_r;

  assign in_range = (CNT_W'(CELL_IDX) < lim);
  // strictly larger wins, so the lowest index keeps a tie
  assign take = in_range && !busy_r && (size_r >= req_size) &&
                (!c_found_i || (size_r > c_size_i));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= c_valid_i;
      if (ctl.clear) begin
        busy_r <= 1'b0;
      end else if (ctl.load_en && (load_idx == MY_IDX)) begin
        busy_r <= 1'b0;
      end else if (ctl.grant_en && (grant_idx == MY_IDX)) begin
        busy_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_en && (load_idx == MY_IDX)) begin
      size_r <= load_data;
    end
    c_found_r <= c_found_i || take;
    c_idx_r   <= take ? MY_IDX : c_idx_i;
    c_size_r  <= take ? size_r : c_size_i;
    c_sum_r   <= (in_range && !busy_r) ? sat_add(c_sum_i, ADD_W'(size_r)) : c_sum_i;
  end

  assign c_valid_o = c_valid_r;
  assign c_found_o = c_found_r;
  assign c_idx_o   = c_idx_r;
  assign c_size_o  = c_size_r;
  assign c_sum_o   = c_sum_r;

endmodule

/* src/wfba_checker.sv */
// Port-level assertions for the worst-fit block allocator, with its bind.
module wfba_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [1:0]                      in_op,
  input logic [wfba_pkg::PORT_SZ_W-1:0]  in_size,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [wfba_pkg::STATUS_W-1:0]   out_status,
  input logic [wfba_pkg::PORT_IX_W-1:0]  out_block_index,
  input logic [wfba_pkg::PORT_SZ_W-1:0]  out_leftover,
  input logic [wfba_pkg::SUM_W-1:0]      out_total_internal,
  input logic [wfba_pkg::SUM_W-1:0]      out_total_external,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [wfba_pkg::CFG_W-1:0]      cfg_blocks_in_use
);
  import wfba_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request in flight: no back-to-back accepts
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while busy");

  // only loads and grants carry an index or leftover
  a_no_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_REFUSED || out_status == ST_REPORT ||
                  out_status == ST_FULL || out_status == ST_CLEARED)
    |-> out_block_index == '0 && out_leftover == '0)
    else $error("index or leftover on a result that has none");

  // external fragmentation appears on reports only
  a_ext_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_REPORT |-> out_total_external == '0)
    else $error("external total outside a report");

  // a clear zeroes the internal total
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_CLEARED |-> out_total_internal == '0)
    else $error("internal total not cleared");

endmodule

bind worst_fit_block_allocator wfba_checker u_wfba_checker (.*);
